// File: src/wpr_pkg.sv
package wpr_pkg;

    localparam int NODES     = 64;
    localparam int IDX_W     = 6;
    localparam int CNT_W     = 7;
    localparam int FRAC_BITS = 24;
    localparam int RANK_W    = FRAC_BITS + 1;
    localparam int ISC_W     = 13;
    localparam int OSD_W     = 14;
    localparam int WA_W      = 14;
    localparam int DEN_W     = ISC_W + OSD_W;
    localparam int NUM_W     = RANK_W + WA_W;
    localparam int DIFF_W    = RANK_W + IDX_W;
    localparam int DAMP_W    = 17;
    localparam int THR_W     = 25;
    localparam int ITER_W    = 10;
    localparam int CFG_W     = 25;
    localparam int CFG_IDX_W = 2;
    localparam int PROD_W    = DAMP_W + RANK_W;

    localparam logic [RANK_W-1:0] ONE_FX    = RANK_W'(1) << FRAC_BITS;
    localparam logic [DAMP_W-1:0] DAMP_ONE  = DAMP_W'(65536);

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DAMPING    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT = 2'd3;

    typedef struct packed {
        logic [NODES-1:0]  col;
        logic [CNT_W-1:0]  indeg;
        logic [CNT_W-1:0]  outdeg;
        logic [ISC_W-1:0]  isc;
        logic [OSD_W-1:0]  osd;
        logic [RANK_W-1:0] rprev;
        logic [RANK_W-1:0] rcur;
    } node_word_t;

    typedef struct packed {
        logic col;
        logic deg;
        logic score;
        logic rprev;
        logic rcur;
    } node_wmask_t;

    typedef struct packed {
        logic [IDX_W-1:0] row_raddr;
        logic             row_we;
        logic [IDX_W-1:0] row_waddr;
        logic [NODES-1:0] row_wdata;
        logic [IDX_W-1:0] node_raddr;
        node_wmask_t      node_wmask;
        logic [IDX_W-1:0] node_waddr;
        node_word_t       node_wdata;
    } mem_req_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [NUM_W-1:0] quot;
    } div_rsp_t;

    typedef enum logic [5:0] {
        ST_CLEAR, ST_IDLE, ST_LD_WR,
        ST_DEG_RD, ST_DEG_LAT, ST_DEG_CNT, ST_DEG_WR,
        ST_SC_RD, ST_SC_LAT, ST_SC_CHK, ST_SC_ACC, ST_SC_WR,
        ST_IN1_GO, ST_IN1_WT, ST_IN2_GO, ST_IN2_WT, ST_INIT_WR,
        ST_IT_RD, ST_IT_LAT, ST_IT_CHK, ST_IT_MUL1, ST_IT_MUL2,
        ST_IT_DGO, ST_IT_DWT, ST_IT_RK1, ST_IT_RK2,
        ST_DF_RD, ST_DF_ACC, ST_DF_CHK,
        ST_SO_RD, ST_SO_CMP, ST_SO_EMIT, ST_SO_WAIT
    } state_t;

    // zero out-degree counts as one half, doubled
    function automatic logic [CNT_W:0] wcount(input logic [CNT_W-1:0] deg);
        logic [CNT_W:0] w;
        w = (deg == '0) ? (CNT_W+1)'(1) : {deg, 1'b0};
        return w;
    endfunction

endpackage

// File: src/wpr_mem.sv
module wpr_mem
    import wpr_pkg::*;
(
    input  logic             aclk,
    input  mem_req_t         req,
    output logic [NODES-1:0] row_rdata,
    output node_word_t       node_rdata
);

    logic [NODES-1:0] row_mem [NODES];
    node_word_t       node_mem [NODES];

    always_ff @(posedge aclk) begin
        if (req.row_we) begin
            row_mem[req.row_waddr] <= req.row_wdata;
        end
        row_rdata <= row_mem[req.row_raddr];
    end

    always_ff @(posedge aclk) begin
        if (req.node_wmask.col) begin
            node_mem[req.node_waddr].col <= req.node_wdata.col;
        end
        if (req.node_wmask.deg) begin
            node_mem[req.node_waddr].indeg  <= req.node_wdata.indeg;
            node_mem[req.node_waddr].outdeg <= req.node_wdata.outdeg;
        end
        if (req.node_wmask.score) begin
            node_mem[req.node_waddr].isc <= req.node_wdata.isc;
            node_mem[req.node_waddr].osd <= req.node_wdata.osd;
        end
        if (req.node_wmask.rprev) begin
            node_mem[req.node_waddr].rprev <= req.node_wdata.rprev;
        end
        if (req.node_wmask.rcur) begin
            node_mem[req.node_waddr].rcur <= req.node_wdata.rcur;
        end
        node_rdata <= node_mem[req.node_raddr];
    end

endmodule

// File: src/wpr_div.sv
module wpr_div
    import wpr_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [NUM_W-1:0]  q_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  den_reg;

    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_sub;
    logic             qbit;
    logic [DEN_W-1:0] rem_next;

    assign rem_sh   = {rem_reg, q_reg[NUM_W-1]};
    assign rem_sub  = rem_sh - {1'b0, den_reg};
    assign qbit     = rem_sh >= {1'b0, den_reg};
    assign rem_next = qbit ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= STEP_W'(NUM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - STEP_W'(1);
                if (cnt_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // quotient bits shift in where the dividend shifts out
    always_ff @(posedge aclk) begin
        if (req.start) begin
            q_reg   <= req.num;
            rem_reg <= '0;
            den_reg <= req.den;
        end else if (busy_reg) begin
            q_reg   <= {q_reg[NUM_W-2:0], qbit};
            rem_reg <= rem_next;
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = q_reg;

endmodule

// File: src/weighted_pagerank_rank_sort.sv
// channel  | dir | handshake          | payload
// s_       | in  | s_tvalid/s_tready  | s_tdata: src_node, dst_node, linked; s_tlast: last
// m_       | out | m_tvalid/m_tready  | m_tdata: position, node_index, rank_value, out_degree
//          |     |                    | m_tlast: last_result
// cfg_     | in  | cfg_wr_en          | cfg_index, cfg_wr_data
//
// a link word is read in ST_IDLE and written back in ST_LD_WR (row and column words)
// after the last word: degrees, scores, then start values from two divider runs,
// then per iteration a rank pass with a run of the 39-step divider per scored
// in-link and a difference pass, then the sort, which can stall on m_tready
// reset and the end of every run start a clearing pass over all 64 rows of the link memories
// no word is taken while a result waits on m_tready or a run is in progress
module weighted_pagerank_rank_sort
    import wpr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,   // src_node[5:0], dst_node[11:6], linked[12]
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [47:0]          m_tdata,   // position, node_index, rank_value, out_degree
    output logic                 m_tlast,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wr_data
);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]  cfg_nodes_reg;
    logic [DAMP_W-1:0] cfg_damp_reg;
    logic [THR_W-1:0]  cfg_thr_reg;
    logic [ITER_W-1:0] cfg_limit_reg;

    logic [IDX_W-1:0]  a_reg, a_next;
    logic [IDX_W-1:0]  b_reg, b_next;
    logic [IDX_W-1:0]  pos_reg, pos_next;
    logic [ITER_W-1:0] it_reg, it_next;
    logic [IDX_W-1:0]  nm1_reg, nm1_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [IDX_W-1:0]  ld_src_reg, ld_src_next;
    logic [IDX_W-1:0]  ld_dst_reg, ld_dst_next;
    logic              ld_link_reg, ld_link_next;
    logic              ld_last_reg, ld_last_next;
    logic [NODES-1:0]  row_w_reg, row_w_next;
    logic [NODES-1:0]  col_w_reg, col_w_next;
    logic [CNT_W-1:0]  in_cnt_reg, in_cnt_next;
    logic [CNT_W-1:0]  out_cnt_reg, out_cnt_next;
    logic [ISC_W-1:0]  isc_reg, isc_next;
    logic [OSD_W-1:0]  osd_reg, osd_next;
    logic [WA_W-1:0]   wa_reg, wa_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [RANK_W-1:0] rp_reg, rp_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [RANK_W-1:0] sigma_reg, sigma_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [RANK_W-1:0] base_reg, base_next;
    logic [RANK_W-1:0] rank0_reg, rank0_next;
    logic [DIFF_W-1:0] diff_reg, diff_next;
    logic [NODES-1:0]  taken_reg, taken_next;
    logic              found_reg, found_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    logic [RANK_W-1:0] best_rank_reg, best_rank_next;
    logic [CNT_W-1:0]  best_deg_reg, best_deg_next;
    logic              m_valid_reg, m_valid_next;
    logic [IDX_W-1:0]  m_pos_reg, m_pos_next;
    logic [IDX_W-1:0]  m_node_reg, m_node_next;
    logic [RANK_W-1:0] m_rank_reg, m_rank_next;
    logic [CNT_W-1:0]  m_deg_reg, m_deg_next;
    logic              m_last_reg, m_last_next;

    mem_req_t         mem_req;
    logic [NODES-1:0] row_rdata;
    node_word_t       node_rdata;
    div_req_t         div_req;
    div_rsp_t         div_rsp;

    wpr_mem u_mem (
        .aclk       (aclk),
        .req        (mem_req),
        .row_rdata  (row_rdata),
        .node_rdata (node_rdata)
    );

    wpr_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    logic              in_acc;
    logic              a_last, b_last, pos_last;
    logic [IDX_W-1:0]  a_adv;
    logic [DAMP_W-1:0] d_eff;
    logic [CNT_W-1:0]  n_clamp;
    logic              it_term;
    logic              it_cont;
    logic [14:0]       wa_full;
    logic [DEN_W-1:0]  den_full;
    logic [NUM_W-1:0]  num_full;
    logic [PROD_W-1:0] prod_full;
    logic [NUM_W:0]    sig_sum;
    logic [RANK_W:0]   r_sum;
    logic [RANK_W-1:0] r_abs;
    logic [24:0]       base_num;

    assign in_acc   = s_tvalid && s_tready;
    assign a_last   = a_reg == nm1_reg;
    assign b_last   = b_reg == nm1_reg;
    assign pos_last = pos_reg == nm1_reg;
    assign a_adv    = a_last ? '0 : a_reg + IDX_W'(1);
    assign d_eff    = (cfg_damp_reg > DAMP_ONE) ? DAMP_ONE : cfg_damp_reg;
    assign n_clamp  = (cfg_nodes_reg == '0) ? CNT_W'(1) :
                      (cfg_nodes_reg > CNT_W'(NODES)) ? CNT_W'(NODES) : cfg_nodes_reg;
    assign it_term  = (b_reg != a_reg) && col_w_reg[b_reg];
    assign it_cont  = ((11'(it_reg) + 11'd1) < 11'(cfg_limit_reg)) &&
                      (diff_reg >= DIFF_W'(cfg_thr_reg));

    assign wa_full   = 15'(node_rdata.indeg) * 15'(wcount(node_rdata.outdeg));
    assign den_full  = DEN_W'(node_rdata.isc) * DEN_W'(node_rdata.osd);
    assign num_full  = NUM_W'(rp_reg) * NUM_W'(wa_reg);
    assign prod_full = PROD_W'(d_eff) * PROD_W'(sigma_reg);
    assign sig_sum   = (NUM_W+1)'(sigma_reg) + (NUM_W+1)'(div_rsp.quot);
    assign r_sum     = (RANK_W+1)'(base_reg) + (RANK_W+1)'(prod_reg[RANK_W+15:16]);
    assign r_abs     = (node_rdata.rcur >= node_rdata.rprev) ?
                       node_rdata.rcur - node_rdata.rprev : node_rdata.rprev - node_rdata.rcur;
    // (1-d)/N with the 2^16 of d cancelled against the fraction
    assign base_num  = 25'(DAMP_ONE - d_eff) << (FRAC_BITS - 16);

    // config
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_nodes_reg <= CNT_W'(64);
            cfg_damp_reg  <= DAMP_W'(55705);
            cfg_thr_reg   <= THR_W'(168);
            cfg_limit_reg <= ITER_W'(1000);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_NODE_COUNT: cfg_nodes_reg <= cfg_wr_data[CNT_W-1:0];
                CFG_DAMPING:    cfg_damp_reg  <= cfg_wr_data[DAMP_W-1:0];
                CFG_THRESHOLD:  cfg_thr_reg   <= cfg_wr_data[THR_W-1:0];
                CFG_ITER_LIMIT: cfg_limit_reg <= cfg_wr_data[ITER_W-1:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:   if (a_reg == IDX_W'(NODES - 1)) state_next = ST_IDLE;
            ST_IDLE:    if (in_acc) state_next = ST_LD_WR;
            ST_LD_WR:   state_next = ld_last_reg ? ST_DEG_RD : ST_IDLE;
            ST_DEG_RD:  state_next = ST_DEG_LAT;
            ST_DEG_LAT: state_next = ST_DEG_CNT;
            ST_DEG_CNT: if (b_last) state_next = ST_DEG_WR;
            ST_DEG_WR:  state_next = a_last ? ST_SC_RD : ST_DEG_RD;
            ST_SC_RD:   state_next = ST_SC_LAT;
            ST_SC_LAT:  state_next = ST_SC_CHK;
            ST_SC_CHK: begin
                if (row_w_reg[b_reg]) state_next = ST_SC_ACC;
                else if (b_last) state_next = ST_SC_WR;
            end
            ST_SC_ACC:  state_next = b_last ? ST_SC_WR : ST_SC_CHK;
            ST_SC_WR:   state_next = a_last ? ST_IN1_GO : ST_SC_RD;
            ST_IN1_GO:  state_next = ST_IN1_WT;
            ST_IN1_WT:  if (div_rsp.done) state_next = ST_IN2_GO;
            ST_IN2_GO:  state_next = ST_IN2_WT;
            ST_IN2_WT:  if (div_rsp.done) state_next = ST_INIT_WR;
            ST_INIT_WR: begin
                if (a_last) state_next = (cfg_limit_reg == '0) ? ST_SO_RD : ST_IT_RD;
            end
            ST_IT_RD:   state_next = ST_IT_LAT;
            ST_IT_LAT:  state_next = ST_IT_CHK;
            ST_IT_CHK: begin
                if (it_term) state_next = ST_IT_MUL1;
                else if (b_last) state_next = ST_IT_RK1;
            end
            ST_IT_MUL1: state_next = ST_IT_MUL2;
            ST_IT_MUL2: begin
                if (den_reg != '0) state_next = ST_IT_DGO;
                else state_next = b_last ? ST_IT_RK1 : ST_IT_CHK;
            end
            ST_IT_DGO:  state_next = ST_IT_DWT;
            ST_IT_DWT:  if (div_rsp.done) state_next = b_last ? ST_IT_RK1 : ST_IT_CHK;
            ST_IT_RK1:  state_next = ST_IT_RK2;
            ST_IT_RK2:  state_next = a_last ? ST_DF_RD : ST_IT_RD;
            ST_DF_RD:   state_next = ST_DF_ACC;
            ST_DF_ACC:  state_next = a_last ? ST_DF_CHK : ST_DF_RD;
            ST_DF_CHK:  state_next = it_cont ? ST_IT_RD : ST_SO_RD;
            ST_SO_RD:   state_next = ST_SO_CMP;
            ST_SO_CMP:  state_next = a_last ? ST_SO_EMIT : ST_SO_RD;
            ST_SO_EMIT: state_next = ST_SO_WAIT;
            ST_SO_WAIT: if (m_tready) state_next = pos_last ? ST_CLEAR : ST_SO_RD;
            default:    state_next = ST_CLEAR;
        endcase
    end

    // datapath and memory / divider requests
    always_comb begin
        a_next = a_reg;  b_next = b_reg;  pos_next = pos_reg;  it_next = it_reg;
        nm1_next = nm1_reg;  n_next = n_reg;
        ld_src_next = ld_src_reg;  ld_dst_next = ld_dst_reg;
        ld_link_next = ld_link_reg;  ld_last_next = ld_last_reg;
        row_w_next = row_w_reg;  col_w_next = col_w_reg;
        in_cnt_next = in_cnt_reg;  out_cnt_next = out_cnt_reg;
        isc_next = isc_reg;  osd_next = osd_reg;  wa_next = wa_reg;
        den_next = den_reg;  rp_next = rp_reg;  num_next = num_reg;
        sigma_next = sigma_reg;  prod_next = prod_reg;
        base_next = base_reg;  rank0_next = rank0_reg;  diff_next = diff_reg;
        taken_next = taken_reg;  found_next = found_reg;
        best_idx_next = best_idx_reg;  best_rank_next = best_rank_reg;
        best_deg_next = best_deg_reg;
        m_valid_next = m_valid_reg;  m_pos_next = m_pos_reg;  m_node_next = m_node_reg;
        m_rank_next = m_rank_reg;  m_deg_next = m_deg_reg;  m_last_next = m_last_reg;

        mem_req            = '0;
        mem_req.row_raddr  = a_reg;
        mem_req.node_raddr = a_reg;
        mem_req.row_waddr  = a_reg;
        mem_req.node_waddr = a_reg;
        div_req            = '0;

        case (state_reg)
            ST_CLEAR: begin
                mem_req.row_we         = 1'b1;
                mem_req.node_wmask.col = 1'b1;
                taken_next             = '0;
                a_next                 = a_reg + IDX_W'(1);
            end
            ST_IDLE: begin
                mem_req.row_raddr  = s_tdata[5:0];
                mem_req.node_raddr = s_tdata[11:6];
                if (in_acc) begin
                    ld_src_next  = s_tdata[5:0];
                    ld_dst_next  = s_tdata[11:6];
                    ld_link_next = s_tdata[12];
                    ld_last_next = s_tlast;
                    n_next       = n_clamp;
                    nm1_next     = IDX_W'(n_clamp - CNT_W'(1));
                    a_next       = '0;
                end
            end
            ST_LD_WR: begin
                mem_req.row_we                  = 1'b1;
                mem_req.row_waddr               = ld_src_reg;
                mem_req.row_wdata               = row_rdata;
                mem_req.row_wdata[ld_dst_reg]   = ld_link_reg;
                mem_req.node_wmask.col          = 1'b1;
                mem_req.node_waddr              = ld_dst_reg;
                mem_req.node_wdata.col          = node_rdata.col;
                mem_req.node_wdata.col[ld_src_reg] = ld_link_reg;
            end
            ST_DEG_LAT: begin
                row_w_next   = row_rdata;
                col_w_next   = node_rdata.col;
                b_next       = '0;
                in_cnt_next  = '0;
                out_cnt_next = '0;
            end
            ST_DEG_CNT: begin
                in_cnt_next  = in_cnt_reg + CNT_W'(col_w_reg[b_reg]);
                out_cnt_next = out_cnt_reg + CNT_W'(row_w_reg[b_reg]);
                b_next       = b_reg + IDX_W'(1);
            end
            ST_DEG_WR: begin
                mem_req.node_wmask.deg    = 1'b1;
                mem_req.node_wdata.indeg  = in_cnt_reg;
                mem_req.node_wdata.outdeg = out_cnt_reg;
                a_next                    = a_adv;
            end
            ST_SC_LAT: begin
                row_w_next = row_rdata;
                b_next     = '0;
                isc_next   = '0;
                osd_next   = '0;
            end
            ST_SC_CHK: begin
                mem_req.node_raddr = b_reg;
                if (!row_w_reg[b_reg]) b_next = b_reg + IDX_W'(1);
            end
            ST_SC_ACC: begin
                isc_next = isc_reg + ISC_W'(node_rdata.indeg);
                osd_next = osd_reg + OSD_W'(wcount(node_rdata.outdeg));
                b_next   = b_reg + IDX_W'(1);
            end
            ST_SC_WR: begin
                mem_req.node_wmask.score = 1'b1;
                mem_req.node_wdata.isc   = isc_reg;
                mem_req.node_wdata.osd   = osd_reg;
                a_next                   = a_adv;
            end
            ST_IN1_GO: begin
                div_req.start = 1'b1;
                div_req.num   = NUM_W'(ONE_FX);
                div_req.den   = DEN_W'(n_reg);
            end
            ST_IN1_WT: if (div_rsp.done) rank0_next = div_rsp.quot[RANK_W-1:0];
            ST_IN2_GO: begin
                div_req.start = 1'b1;
                div_req.num   = NUM_W'(base_num);
                div_req.den   = DEN_W'(n_reg);
            end
            ST_IN2_WT: if (div_rsp.done) base_next = div_rsp.quot[RANK_W-1:0];
            ST_INIT_WR: begin
                mem_req.node_wmask.rprev = 1'b1;
                mem_req.node_wdata.rprev = rank0_reg;
                a_next                   = a_adv;
                it_next                  = '0;
                pos_next                 = '0;
                found_next               = 1'b0;
            end
            ST_IT_LAT: begin
                col_w_next = node_rdata.col;
                wa_next    = wa_full[WA_W-1:0];
                sigma_next = '0;
                b_next     = '0;
            end
            ST_IT_CHK: begin
                mem_req.node_raddr = b_reg;
                if (!it_term) b_next = b_reg + IDX_W'(1);
            end
            ST_IT_MUL1: begin
                den_next = den_full;
                rp_next  = node_rdata.rprev;
            end
            ST_IT_MUL2: begin
                num_next = num_full;
                // a link whose source has no scored targets adds nothing
                if (den_reg == '0) b_next = b_reg + IDX_W'(1);
            end
            ST_IT_DGO: begin
                div_req.start = 1'b1;
                div_req.num   = num_reg;
                div_req.den   = den_reg;
            end
            ST_IT_DWT: begin
                if (div_rsp.done) begin
                    sigma_next = (sig_sum > (NUM_W+1)'(ONE_FX)) ? ONE_FX :
                                 sig_sum[RANK_W-1:0];
                    b_next     = b_reg + IDX_W'(1);
                end
            end
            ST_IT_RK1: prod_next = prod_full;
            ST_IT_RK2: begin
                mem_req.node_wmask.rcur = 1'b1;
                mem_req.node_wdata.rcur = (r_sum > (RANK_W+1)'(ONE_FX)) ? ONE_FX :
                                          r_sum[RANK_W-1:0];
                a_next                  = a_adv;
                if (a_last) diff_next = '0;
            end
            ST_DF_ACC: begin
                diff_next                = diff_reg + DIFF_W'(r_abs);
                mem_req.node_wmask.rprev = 1'b1;
                mem_req.node_wdata.rprev = node_rdata.rcur;
                a_next                   = a_adv;
            end
            ST_DF_CHK: begin
                it_next    = it_reg + ITER_W'(1);
                pos_next   = '0;
                found_next = 1'b0;
            end
            ST_SO_CMP: begin
                // strict compare keeps the lower index on equal ranks
                if (!taken_reg[a_reg] &&
                    (!found_reg || node_rdata.rprev > best_rank_reg)) begin
                    best_idx_next  = a_reg;
                    best_rank_next = node_rdata.rprev;
                    best_deg_next  = node_rdata.outdeg;
                    found_next     = 1'b1;
                end
                a_next = a_adv;
            end
            ST_SO_EMIT: begin
                m_valid_next            = 1'b1;
                m_pos_next              = pos_reg;
                m_node_next             = best_idx_reg;
                m_rank_next             = best_rank_reg;
                m_deg_next              = best_deg_reg;
                m_last_next             = pos_last;
                taken_next[best_idx_reg] = 1'b1;
            end
            ST_SO_WAIT: begin
                if (m_tready) begin
                    m_valid_next = 1'b0;
                    pos_next     = pos_reg + IDX_W'(1);
                    found_next   = 1'b0;
                    a_next       = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            a_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            a_reg       <= a_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        b_reg <= b_next;  pos_reg <= pos_next;  it_reg <= it_next;
        nm1_reg <= nm1_next;  n_reg <= n_next;
        ld_src_reg <= ld_src_next;  ld_dst_reg <= ld_dst_next;
        ld_link_reg <= ld_link_next;  ld_last_reg <= ld_last_next;
        row_w_reg <= row_w_next;  col_w_reg <= col_w_next;
        in_cnt_reg <= in_cnt_next;  out_cnt_reg <= out_cnt_next;
        isc_reg <= isc_next;  osd_reg <= osd_next;  wa_reg <= wa_next;
        den_reg <= den_next;  rp_reg <= rp_next;  num_reg <= num_next;
        sigma_reg <= sigma_next;  prod_reg <= prod_next;
        base_reg <= base_next;  rank0_reg <= rank0_next;  diff_reg <= diff_next;
        taken_reg <= taken_next;  found_reg <= found_next;
        best_idx_reg <= best_idx_next;  best_rank_reg <= best_rank_next;
        best_deg_reg <= best_deg_next;
        m_pos_reg <= m_pos_next;  m_node_reg <= m_node_next;
        m_rank_reg <= m_rank_next;  m_deg_reg <= m_deg_next;  m_last_reg <= m_last_next;
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, m_deg_reg, m_rank_reg, m_node_reg, m_pos_reg};
    assign m_tlast  = m_last_reg;

    a_idle_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid)
        else $error("input ready while a result is pending");

    a_last_word_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input ready right after the last word");

    a_div_start_free: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_result_in_sort: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (state_reg == ST_SO_WAIT))
        else $error("result valid outside the emit wait");

endmodule

// File: sim/tb_weighted_pagerank_rank_sort.sv
`timescale 1ns / 1ps

module tb_weighted_pagerank_rank_sort;
    import wpr_pkg::*;

    localparam int LIMIT_CYCLES = 60000000;
    localparam int RANDOM_ITEMS = 450;

    typedef struct packed {
        logic [5:0]  position;
        logic [5:0]  node_index;
        logic [24:0] rank_value;
        logic [6:0]  out_degree;
        logic        last_result;
    } rank_entry_t;

    class rank_scoreboard;
        rank_entry_t      expected_q[$];
        bit               links[64][64];
        longint unsigned  node_cfg = 64, damp_cfg = 55705, thr_cfg = 168, iter_cfg = 1000;
        int               errors = 0;
        int               runs = 0;
        int               checked = 0;

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_NODE_COUNT: node_cfg = val[6:0];
                CFG_DAMPING:    damp_cfg = val[16:0];
                CFG_THRESHOLD:  thr_cfg  = val[24:0];
                CFG_ITER_LIMIT: iter_cfg = val[9:0];
                default: ;
            endcase
        endfunction

        function longint unsigned weight_of(longint unsigned deg);
            return (deg == 0) ? 1 : 2 * deg;
        endfunction

        // applies one link word; a word marked last yields the ranked listing
        function void note_link(logic [5:0] src, logic [5:0] dst, logic linked, logic last);
            longint unsigned n, d, base, it, diff, wa, sigma, den, r, one;
            longint unsigned indeg[64], outdeg[64], isc[64], osd[64], rprev[64], rcur[64];
            bit taken[64];
            int best;
            bit found;
            rank_entry_t e;
            links[src][dst] = linked;
            if (!last) return;
            runs++;
            one = 64'd1 << 24;
            n = node_cfg;
            if (n < 1) n = 1;
            if (n > 64) n = 64;
            for (int a = 0; a < n; a++) begin
                indeg[a] = 0;
                outdeg[a] = 0;
                for (int b = 0; b < n; b++) begin
                    if (links[a][b]) outdeg[a]++;
                    if (links[b][a]) indeg[a]++;
                end
            end
            for (int a = 0; a < n; a++) begin
                isc[a] = 0;
                osd[a] = 0;
                for (int b = 0; b < n; b++)
                    if (links[a][b]) begin
                        isc[a] += indeg[b];
                        osd[a] += weight_of(outdeg[b]);
                    end
            end
            d = (damp_cfg > 65536) ? 65536 : damp_cfg;
            base = ((65536 - d) << 24) / (65536 * n);
            for (int a = 0; a < n; a++) rprev[a] = one / n;
            it = 0;
            diff = thr_cfg;
            while (it < iter_cfg && diff >= thr_cfg) begin
                it++;
                for (int a = 0; a < n; a++) begin
                    wa = indeg[a] * weight_of(outdeg[a]);
                    sigma = 0;
                    for (int b = 0; b < n; b++) begin
                        if (b == a || !links[b][a]) continue;
                        den = isc[b] * osd[b];
                        if (den == 0) continue;
                        sigma += rprev[b] * wa / den;
                        if (sigma > one) sigma = one;
                    end
                    r = base + ((d * sigma) >> 16);
                    rcur[a] = (r > one) ? one : r;
                end
                diff = 0;
                for (int a = 0; a < n; a++) begin
                    diff += (rcur[a] >= rprev[a]) ? rcur[a] - rprev[a] : rprev[a] - rcur[a];
                    rprev[a] = rcur[a];
                end
            end
            for (int a = 0; a < 64; a++) taken[a] = 0;
            for (int pos = 0; pos < n; pos++) begin
                best = 0;
                found = 0;
                for (int a = 0; a < n; a++) begin
                    if (taken[a]) continue;
                    if (!found || rprev[a] > rprev[best]) begin
                        best = a;
                        found = 1;
                    end
                end
                taken[best] = 1;
                e.position    = 6'(pos);
                e.node_index  = 6'(best);
                e.rank_value  = 25'(rprev[best]);
                e.out_degree  = 7'(outdeg[best]);
                e.last_result = (pos + 1 == n);
                expected_q.push_back(e);
            end
            for (int a = 0; a < 64; a++)
                for (int b = 0; b < 64; b++) links[a][b] = 0;
        endfunction

        function void check_result(rank_entry_t got);
            rank_entry_t want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected word pos=%0d node=%0d rank=%h odeg=%0d last=%0b",
                         $time, got.position, got.node_index, got.rank_value,
                         got.out_degree, got.last_result);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got !== want) begin
                $display("%0t: mismatch exp pos=%0d node=%0d rank=%h odeg=%0d last=%0b",
                         $time, want.position, want.node_index, want.rank_value,
                         want.out_degree, want.last_result);
                $display("%0t:          act pos=%0d node=%0d rank=%h odeg=%0d last=%0b",
                         $time, got.position, got.node_index, got.rank_value,
                         got.out_degree, got.last_result);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk = 0;
    logic                 aresetn = 0;
    logic                 s_tvalid = 0;
    logic                 s_tready;
    logic [15:0]          s_tdata = '0;
    logic                 s_tlast = 0;
    logic                 m_tvalid;
    logic                 m_tready = 0;
    logic [47:0]          m_tdata;
    logic                 m_tlast;
    logic                 cfg_wr_en = 0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wr_data = '0;

    rank_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int words_sent = 0;
    longint cycles = 0;

    weighted_pagerank_rank_sort u_dut (.*);

    always begin
        #10 aclk = 1;
        #10 aclk = 0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("** weighted_pagerank_rank_sort: FAILED **");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result({m_tdata[5:0], m_tdata[11:6], m_tdata[36:12],
                             m_tdata[43:37], m_tlast});
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        cfg_wr_en   <= 1;
        cfg_index   <= idx;
        cfg_wr_data <= CFG_W'(val);
        @(posedge aclk);
        cfg_wr_en   <= 0;
        sb.write_reg(idx, CFG_W'(val));
    endtask

    task automatic set_graph_regs(int n, int d, int thr, int lim);
        write_reg(CFG_NODE_COUNT, n);
        write_reg(CFG_DAMPING, d);
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_ITER_LIMIT, lim);
    endtask

    task automatic send_link(int src, int dst, int linked, int last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= {3'b0, 1'(linked), 6'(dst), 6'(src)};
        s_tlast  <= 1'(last);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_link(6'(src), 6'(dst), 1'(linked), 1'(last));
        words_sent++;
    endtask

    // hold off until the listing is out and the clearing pass is done
    task automatic wait_drained();
        s_tvalid <= 0;
        @(posedge aclk);
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (120) @(posedge aclk);
    endtask

    task automatic random_graph(int items, int n);
        int src, dst;
        for (int k = 0; k < items; k++) begin
            // mostly links inside the active nodes, now and then anywhere
            src = ($urandom_range(7) == 0) ? int'($urandom_range(63))
                                           : int'($urandom_range(n - 1));
            dst = ($urandom_range(7) == 0) ? int'($urandom_range(63))
                                           : int'($urandom_range(n - 1));
            send_link(src, dst, int'($urandom_range(3) != 0), int'(k == items - 1));
        end
    endtask

    initial begin
        int n, items;
        repeat (9) @(posedge aclk);
        aresetn <= 1;
        repeat (80) @(posedge aclk);

        // reset settings: self links, top index, a cleared link
        send_link(0, 0, 1, 0);
        send_link(63, 63, 1, 0);
        send_link(63, 0, 1, 0);
        send_link(0, 1, 1, 0);
        send_link(1, 2, 1, 0);
        send_link(2, 0, 1, 0);
        send_link(1, 2, 0, 0);
        send_link(5, 63, 1, 1);
        wait_drained();

        // zero node count, zero iteration limit
        set_graph_regs(0, 0, 0, 0);
        send_link(0, 0, 1, 0);
        send_link(3, 0, 1, 1);
        wait_drained();

        // oversized count and damping, one iteration, huge threshold
        set_graph_regs(127, 131071, 16777216, 1);
        send_link(10, 20, 1, 0);
        send_link(20, 10, 1, 0);
        send_link(42, 10, 1, 0);
        send_link(7, 7, 1, 0);
        send_link(50, 51, 0, 0);
        send_link(62, 10, 1, 1);
        wait_drained();

        // full damping, zero threshold, highest limit on a two-node cycle
        set_graph_regs(2, 65536, 0, 1023);
        send_link(0, 1, 1, 0);
        send_link(1, 0, 1, 0);
        send_link(1, 1, 1, 1);
        wait_drained();

        while (words_sent < RANDOM_ITEMS + 19) begin
            if (words_sent < 19 + RANDOM_ITEMS / 3) begin
                send_idle_pct = 37;
                recv_idle_pct = 86;
            end else if (words_sent < 19 + 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 86;
                recv_idle_pct = 37;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            n = ($urandom_range(5) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 10);
            items = $urandom_range(6, 30);
            set_graph_regs(($urandom_range(9) == 0) ? $urandom_range(127) : n,
                           ($urandom_range(7) == 0) ? $urandom_range(131071)
                                                    : $urandom_range(65536),
                           ($urandom_range(7) == 0) ? $urandom_range(33554431)
                                                    : $urandom_range(20000),
                           $urandom_range(1, 30));
            if (sb.node_cfg > 24 && $urandom_range(1) == 0)
                write_reg(CFG_NODE_COUNT, n);
            random_graph(items, n);
            wait_drained();
        end

        repeat (300) @(posedge aclk);
        $display("sent %0d link words over %0d graph runs, %0d ranked words checked",
                 words_sent, sb.runs, sb.checked);
        $display("covered node count, damping, threshold and limit extremes plus stalls");
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("** weighted_pagerank_rank_sort: PASSED **");
        end else begin
            $display("errors %0d, words still expected %0d", sb.errors, sb.expected_q.size());
            $display("** weighted_pagerank_rank_sort: FAILED **");
        end
        $finish;
    end

endmodule
